[rtl/core/olc_pkg.sv]
package olc_pkg;

    // List geometry
    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Fixed beat field widths
    localparam int MODE_W   = 2;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int RDV_W    = 32;
    localparam int CNTF_W   = 5;
    localparam int STATUS_W = 2;

    // Width used to compare a position against the entry count
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [MODE_W-1:0]     mode_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [RDV_W-1:0]      rdv_t;
    typedef logic [CNTF_W-1:0]     cntf_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CMP_W-1:0]      cmp_t;
    typedef logic [QPTR_W-1:0]     qptr_t;
    typedef logic [QCNT_W-1:0]     qcnt_t;

    // Request modes
    localparam mode_t MODE_APPEND = 2'd0;
    localparam mode_t MODE_READ   = 2'd1;
    localparam mode_t MODE_REMAT  = 2'd2;
    localparam mode_t MODE_REMALL = 2'd3;

    // Result status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    // Classified command handed from front to back
    typedef struct packed {
        mode_t mode;
        pos_t  position;
        word_t value;
    } cmd_t;

    typedef struct packed {
        rdv_t    read_value;
        cntf_t   count;
        cntf_t   removed;
        status_t status;
    } result_t;

endpackage

[rtl/core/olc_if.sv]
interface olc_req_if;
    logic            valid;
    logic            ready;
    olc_pkg::mode_t  mode;
    olc_pkg::pos_t   position;
    olc_pkg::value_t value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface olc_rsp_if;
    logic              valid;
    logic              ready;
    olc_pkg::rdv_t     read_value;
    olc_pkg::cntf_t    count;
    olc_pkg::cntf_t    removed;
    olc_pkg::status_t  status;

    modport source (output valid, output read_value, output count, output removed,
                    output status, input ready);
    modport sink   (input valid, input read_value, input count, input removed,
                    input status, output ready);
endinterface

[rtl/core/olc_front.sv]
module olc_front (
    input  logic              clk,
    input  logic              rst_n,
    olc_req_if.sink           req,
    output logic              push_valid,
    input  logic              push_ready,
    output olc_pkg::cmd_t     push_cmd
);

    logic          stage_valid_reg;
    logic          stage_valid_next;
    olc_pkg::cmd_t stage_reg;
    olc_pkg::cmd_t stage_next;
    logic          take;

    assign req.ready  = !stage_valid_reg || push_ready;
    assign take       = req.valid && req.ready;
    assign push_valid = stage_valid_reg;
    assign push_cmd   = stage_reg;

    // Capture a beat and trim the value to the stored word width
    always_comb
    begin
        stage_next       = stage_reg;
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_next.mode     = req.mode;
            stage_next.position = req.position;
            stage_next.value    = olc_pkg::word_t'(req.value);
            stage_valid_next    = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

endmodule

[rtl/core/olc_queue.sv]
module olc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  olc_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output olc_pkg::cmd_t pop_cmd
);

    olc_pkg::cmd_t q_mem [olc_pkg::QDEPTH];
    olc_pkg::qptr_t wr_ptr_reg, wr_ptr_next;
    olc_pkg::qptr_t rd_ptr_reg, rd_ptr_next;
    olc_pkg::qcnt_t fill_reg, fill_next;
    logic do_push;
    logic do_pop;

    assign push_ready = (fill_reg != olc_pkg::qcnt_t'(olc_pkg::QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = q_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == olc_pkg::qptr_t'(olc_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == olc_pkg::qptr_t'(olc_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/core/olc_back.sv]
module olc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  olc_pkg::cmd_t cmd,
    olc_rsp_if.source     rsp
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_RDWAIT = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]       state_reg, state_next;
    olc_pkg::cnt_t    count_reg, count_next;
    olc_pkg::cmd_t    cur_reg, cur_next;
    olc_pkg::cnt_t    scan_idx_reg, scan_idx_next;
    olc_pkg::cnt_t    keep_reg, keep_next;
    olc_pkg::cnt_t    rem_reg, rem_next;
    logic             pend_reg, pend_next;
    olc_pkg::idx_t    pend_idx_reg, pend_idx_next;
    olc_pkg::result_t res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    olc_pkg::result_t out_reg;

    // Entry memory: one write and one registered read per cycle
    olc_pkg::word_t   mem [olc_pkg::CAPACITY];
    olc_pkg::word_t   rdata_reg;
    logic             mem_we;
    olc_pkg::idx_t    mem_waddr;
    olc_pkg::word_t   mem_wdata;
    logic             mem_re;
    olc_pkg::idx_t    mem_raddr;

    logic             slot_free;
    logic             load_out;
    logic             in_range;
    logic             drop;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign load_out  = (state_reg == S_DONE) && slot_free;
    assign cmd_ready = (state_reg == S_IDLE);
    assign in_range  = olc_pkg::cmp_t'(cmd.position) < olc_pkg::cmp_t'(count_reg);

    // Match test for the scan: index for remove-at, value for remove-all
    assign drop = (cur_reg.mode == olc_pkg::MODE_REMAT)
                  ? (pend_idx_reg == olc_pkg::idx_t'(cur_reg.position))
                  : (rdata_reg == cur_reg.value);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        scan_idx_next = scan_idx_reg;
        keep_next     = keep_reg;
        rem_next      = rem_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next            = cmd;
                    res_next.read_value = '0;
                    res_next.count      = olc_pkg::cntf_t'(count_reg);
                    res_next.removed    = '0;
                    res_next.status     = olc_pkg::ST_OK;
                    scan_idx_next       = '0;
                    keep_next           = '0;
                    rem_next            = '0;
                    pend_next           = 1'b0;
                    state_next          = S_DONE;
                    unique case (cmd.mode)
                        olc_pkg::MODE_APPEND:
                        begin
                            if (count_reg == olc_pkg::cnt_t'(olc_pkg::CAPACITY))
                            begin
                                res_next.status = olc_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = olc_pkg::idx_t'(count_reg);
                                mem_wdata      = cmd.value;
                                count_next     = count_reg + 1'b1;
                                res_next.count = olc_pkg::cntf_t'(count_reg + 1'b1);
                            end
                        end
                        olc_pkg::MODE_READ:
                        begin
                            if (in_range)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = olc_pkg::idx_t'(cmd.position);
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                res_next.status = olc_pkg::ST_RANGE;
                            end
                        end
                        olc_pkg::MODE_REMAT:
                        begin
                            if (in_range)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                res_next.status = olc_pkg::ST_RANGE;
                            end
                        end
                        olc_pkg::MODE_REMALL:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                res_next.read_value = olc_pkg::rdv_t'(rdata_reg);
                state_next          = S_DONE;
            end
            S_SCAN:
            begin
                // Read the next entry while the previous one is kept or dropped
                if (scan_idx_reg < count_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = olc_pkg::idx_t'(scan_idx_reg);
                    scan_idx_next = scan_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = olc_pkg::idx_t'(scan_idx_reg);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (drop)
                    begin
                        rem_next = rem_reg + 1'b1;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = olc_pkg::idx_t'(keep_reg);
                        mem_wdata = rdata_reg;
                        keep_next = keep_reg + 1'b1;
                    end
                end
                else if (scan_idx_reg == count_reg)
                begin
                    count_next       = keep_reg;
                    res_next.count   = olc_pkg::cntf_t'(keep_reg);
                    res_next.removed = olc_pkg::cntf_t'(rem_reg);
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        scan_idx_reg <= scan_idx_next;
        keep_reg     <= keep_next;
        rem_reg      <= rem_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_reg.read_value;
    assign rsp.count      = out_reg.count;
    assign rsp.removed    = out_reg.removed;
    assign rsp.status     = out_reg.status;

endmodule

[rtl/core/ordered_list_with_compaction.sv]
// Channel  Dir  Beat fields                          Handshake
// req      in   mode, position, value                valid / ready
// rsp      out  read_value, count, removed, status   valid / ready
//
// One rsp beat per req beat, in order. Past the input stage and queue, append writes
// directly, read waits on the registered read, and remove-at and remove-all walk the
// entry memory one entry per cycle via its single read port, writing survivors down.
// rst_n clears the count and all handshake state; entry contents are not cleared.
// A two-deep command queue lets requests keep arriving while a scan runs or rsp stalls.
module ordered_list_with_compaction (
    input  logic  clk,
    input  logic  rst_n,
    olc_req_if.sink   req,
    olc_rsp_if.source rsp
);

    logic          push_valid;
    logic          push_ready;
    olc_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    olc_pkg::cmd_t pop_cmd;

    olc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    olc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    olc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd        (pop_cmd),
        .rsp        (rsp)
    );

endmodule
